// ===== sv/whtr_pkg.sv =====
package whtr_pkg;

	// Default sizes of the window stack
	localparam int MAX_WINDOWS_DEF = 16;
	localparam int COORD_BITS_DEF  = 12;

	// Bounds per window: left, top, right, bottom
	localparam int RECT_FIELDS = 4;

	// Item kind carried on the input tuser bit
	localparam logic KIND_CLICK = 1'b1;

endpackage

// ===== sv/window_hit_test_raise.sv =====
// Window stack with click hit testing and raise to front. An add item (tuser 0) stores a
// rectangle with inclusive bounds under the next id, counting from 1, and puts it at the front;
// adds beyond MAX_WINDOWS are dropped and no add gives a result. A click item (tuser 1) gives
// one result: tuser 1 and the id of the front-most window holding the point, which then moves
// to the front keeping the order of the rest, or tuser 0 and id 0 when no window holds it.
// Rectangles and the stack order sit in two one-read one-write memories; valid entries are
// tracked by the window count, so no clearing pass follows reset. A click runs a pipelined
// front-to-back scan through the order and rectangle memory reads; on a hit, and for each
// stored add, a shift through the order memory port then moves the entry to the front. One
// item is in work at a time; a finished result waits in the output register and does not
// block the next input.
module window_hit_test_raise #(
	parameter int MAX_WINDOWS = whtr_pkg::MAX_WINDOWS_DEF,
	parameter int COORD_BITS  = whtr_pkg::COORD_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// left, top, right, bottom, point_x, point_y from bit 0 up, zero fill to bytes
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]            s_tdata,
	// kind: 0 add window, 1 click
	input  logic                                         s_tuser,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// window_id from bit 0 up, zero fill to bytes
	output logic [(($clog2(MAX_WINDOWS+1)+7)/8)*8-1:0]   m_tdata,
	// hit
	output logic                                         m_tuser
);
	import whtr_pkg::*;

	localparam int IDX_W       = $clog2(MAX_WINDOWS);
	localparam int CNT_W       = $clog2(MAX_WINDOWS+1);
	localparam int OUT_TDATA_W = ((CNT_W+7)/8)*8;
	localparam int RECT_W      = RECT_FIELDS * COORD_BITS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_pos_q;
	logic             is_click_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] front_q;

	logic             v_s1, v_s2;
	logic [IDX_W-1:0] pos_s1, pos_s2, slot_s2;

	logic             wr_v_s1;
	logic [IDX_W-1:0] wr_addr_s1;
	logic             wr_front_s1;

	logic             res_hit_q;
	logic [CNT_W-1:0] res_id_q;
	logic             m_valid_q;
	logic             m_hit_q;
	logic [CNT_W-1:0] m_id_q;

	logic [COORD_BITS-1:0] pt_x_q, pt_y_q;

	logic             in_acc, is_click, full, rect_we, issue, contains;
	logic             hit_now, miss_now, leave, out_free;
	logic [IDX_W-1:0] order_raddr, order_rdata, order_wdata;

	// Input handshake and decode
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign is_click = (s_tuser == KIND_CLICK);
	assign full     = (count_q == CNT_W'(MAX_WINDOWS));
	assign rect_we  = in_acc && !is_click && !full;

	// Scan issue and compare outcome
	assign issue    = (state_q == ST_SCAN) && (issue_pos_q < count_q);
	assign hit_now  = v_s2 && contains;
	assign miss_now = v_s2 && !contains && (CNT_W'(pos_s2) == count_q - CNT_W'(1));
	assign leave    = hit_now || miss_now;
	assign out_free = !m_valid_q || m_tready;

	// Order memory: scan reads forward, shift reads one below the write point
	assign order_raddr = (state_q == ST_SCAN) ? issue_pos_q[IDX_W-1:0] : cur_q - IDX_W'(1);
	assign order_wdata = wr_front_s1 ? front_q : order_rdata;

	whtr_order_store #(
		.MAX_WINDOWS(MAX_WINDOWS)
	) u_order (
		.clk    (clk),
		.wr_en  (wr_v_s1),
		.wr_addr(wr_addr_s1),
		.wr_data(order_wdata),
		.rd_addr(order_raddr),
		.rd_data(order_rdata)
	);

	whtr_rect_store #(
		.MAX_WINDOWS(MAX_WINDOWS),
		.COORD_BITS (COORD_BITS)
	) u_rect (
		.clk     (clk),
		.wr_en   (rect_we),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_rect (s_tdata[RECT_W-1:0]),
		.rd_addr (order_rdata),
		.point_x (pt_x_q),
		.point_y (pt_y_q),
		.contains(contains)
	);

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issue_pos_q <= '0;
			is_click_q  <= 1'b0;
			cur_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			wr_v_s1     <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			v_s1    <= issue && !leave;
			v_s2    <= v_s1 && !leave;
			wr_v_s1 <= (state_q == ST_SHIFT);
			if (issue) begin
				issue_pos_q <= issue_pos_q + CNT_W'(1);
			end
			// Load a finished result, or drop the one taken downstream
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						is_click_q <= is_click;
						if (is_click) begin
							issue_pos_q <= '0;
							state_q     <= (count_q == '0) ? ST_OUT : ST_SCAN;
						end else if (!full) begin
							cur_q   <= count_q[IDX_W-1:0];
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						cur_q   <= pos_s2;
						state_q <= ST_SHIFT;
					end else if (miss_now) begin
						state_q <= ST_OUT;
					end
				end
				ST_SHIFT: begin
					if (cur_q != '0) begin
						cur_q <= cur_q - IDX_W'(1);
					end else begin
						state_q <= is_click_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pos_s1      <= issue_pos_q[IDX_W-1:0];
		pos_s2      <= pos_s1;
		slot_s2     <= order_rdata;
		wr_addr_s1  <= cur_q;
		wr_front_s1 <= (cur_q == '0);
		if (in_acc) begin
			pt_x_q <= s_tdata[5*COORD_BITS-1:4*COORD_BITS];
			pt_y_q <= s_tdata[6*COORD_BITS-1:5*COORD_BITS];
			if (!is_click) begin
				front_q <= count_q[IDX_W-1:0];
			end else begin
				res_hit_q <= 1'b0;
				res_id_q  <= '0;
			end
		end
		if (state_q == ST_SCAN) begin
			if (hit_now) begin
				front_q   <= slot_s2;
				res_hit_q <= 1'b1;
				res_id_q  <= CNT_W'(slot_s2) + CNT_W'(1);
			end else if (miss_now) begin
				res_hit_q <= 1'b0;
				res_id_q  <= '0;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			m_hit_q <= res_hit_q;
			m_id_q  <= res_id_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(m_id_q);
	assign m_tuser  = m_hit_q;

	// Window count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOWS))
		else $error("window count above capacity");

	// Scan pipeline holds nothing outside the scan
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_SCAN))
		else $error("scan stage live outside scan");

	// Order writes come only from the shift sequence
	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> $past(state_q == ST_SHIFT))
		else $error("order write without shift");

	// A miss reports id zero
	a_miss_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("nonzero id on miss");

	// A hit names a stored window
	a_hit_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_id_q != '0) && (m_id_q <= count_q)))
		else $error("hit id out of range");

endmodule

// ===== sv/whtr_rect_store.sv =====
module whtr_rect_store #(
	parameter int MAX_WINDOWS = whtr_pkg::MAX_WINDOWS_DEF,
	parameter int COORD_BITS  = whtr_pkg::COORD_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             wr_en,
	input  logic [$clog2(MAX_WINDOWS)-1:0]                   wr_addr,
	input  logic [whtr_pkg::RECT_FIELDS*COORD_BITS-1:0]      wr_rect,
	input  logic [$clog2(MAX_WINDOWS)-1:0]                   rd_addr,
	input  logic [COORD_BITS-1:0]                            point_x,
	input  logic [COORD_BITS-1:0]                            point_y,
	output logic                                             contains
);
	import whtr_pkg::*;

	localparam int RECT_W = RECT_FIELDS * COORD_BITS;

	logic [RECT_W-1:0] mem [MAX_WINDOWS];
	logic [RECT_W-1:0] rd_q;
	logic [COORD_BITS-1:0] r_left, r_top, r_right, r_bottom;

	// Write one rectangle, read one with a registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rect;
		end
		rd_q <= mem[rd_addr];
	end

	// Test the held point against the inclusive bounds
	assign r_left   = rd_q[COORD_BITS-1:0];
	assign r_top    = rd_q[2*COORD_BITS-1:COORD_BITS];
	assign r_right  = rd_q[3*COORD_BITS-1:2*COORD_BITS];
	assign r_bottom = rd_q[4*COORD_BITS-1:3*COORD_BITS];

	assign contains = (r_left <= point_x) && (point_x <= r_right) &&
		(r_top <= point_y) && (point_y <= r_bottom);

endmodule

// ===== sv/whtr_order_store.sv =====
module whtr_order_store #(
	parameter int MAX_WINDOWS = whtr_pkg::MAX_WINDOWS_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_WINDOWS)-1:0] wr_addr,
	input  logic [$clog2(MAX_WINDOWS)-1:0] wr_data,
	input  logic [$clog2(MAX_WINDOWS)-1:0] rd_addr,
	output logic [$clog2(MAX_WINDOWS)-1:0] rd_data
);
	import whtr_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOWS);

	logic [IDX_W-1:0] mem [MAX_WINDOWS];
	logic [IDX_W-1:0] rd_q;

	// Slot number at each stack position, front at position zero
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
